// ----- hw/rtl/blowfish_key1_cipher_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the KEY1 Blowfish cipher.
// Each macro checks one implication on the rising clock edge, outside reset.
// ---------------------------------------------------------------------------
`ifndef BLOWFISH_KEY1_CIPHER_MACROS_SVH
`define BLOWFISH_KEY1_CIPHER_MACROS_SVH

// Same-cycle implication.
`define BFK_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bfk assertion failed");

// Next-cycle implication.
`define BFK_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bfk assertion failed");

`endif

// ----- hw/rtl/bfk_pkg.sv -----
// ---------------------------------------------------------------------------
// bfk_pkg
// Shared constants and helpers of the KEY1 Blowfish cipher.
// ---------------------------------------------------------------------------
package bfk_pkg;

	// Table geometry.
	localparam int TABLE_WORDS = 1042;
	localparam int IDX_W       = 11;
	localparam int WORD_W      = 32;

	// Base addresses of the four S-boxes.
	localparam logic [IDX_W-1:0] SBOX0 = 11'h012;
	localparam logic [IDX_W-1:0] SBOX1 = 11'h112;
	localparam logic [IDX_W-1:0] SBOX2 = 11'h212;
	localparam logic [IDX_W-1:0] SBOX3 = 11'h312;

	// Round key bookkeeping.
	localparam logic [IDX_W-1:0] KEY_LAST  = 11'h011;
	localparam logic [IDX_W-1:0] WHITEN_E0 = 11'h010;
	localparam logic [IDX_W-1:0] WHITEN_E1 = 11'h011;
	localparam logic [IDX_W-1:0] WHITEN_D0 = 11'h001;
	localparam logic [IDX_W-1:0] WHITEN_D1 = 11'h000;

	// Operation codes.
	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_KEY  = 2'd1;
	localparam logic [1:0] FUNC_ENC  = 2'd2;
	localparam logic [1:0] FUNC_DEC  = 2'd3;

	// Reverse the byte order of a word.
	function automatic logic [WORD_W-1:0] byte_swap(input logic [WORD_W-1:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

// ----- hw/rtl/bfk_ifs.sv -----
// ---------------------------------------------------------------------------
// bfk channel interfaces
// Request, response and configuration channels with valid and ready.
// ---------------------------------------------------------------------------
interface bfk_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [10:0] table_index;
	logic [31:0] table_word;
	logic        third_pass;
	logic [31:0] block_low;
	logic [31:0] block_high;
	modport source (output valid, func, table_index, table_word, third_pass,
		block_low, block_high, input ready);
	modport sink (input valid, func, table_index, table_word, third_pass,
		block_low, block_high, output ready);
endinterface

interface bfk_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_low;
	logic [31:0] out_high;
	modport source (output valid, out_low, out_high, input ready);
	modport sink (input valid, out_low, out_high, output ready);
endinterface

interface bfk_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- hw/rtl/blowfish_key1_cipher.sv -----
// ---------------------------------------------------------------------------
// blowfish_key1_cipher
// KEY1 Blowfish cipher with a loadable key table and an on-chip key schedule.
// ---------------------------------------------------------------------------
// Channel  Dir  Contents
// req      in   func, table_index, table_word, third_pass, block_low/high
// rsp      out  out_low, out_high
// cfg      in   game_code write data
//
// An encrypt or decrypt runs 16 rounds; each of the 16 rounds makes five
// reads through the single table read port.
// A key schedule runs 2 or 3 key passes, each of 523 block encryptions
// (two for the key words, 521 to refill the table) through the same read port.
// One request is in work at a time; the next is taken while a result waits.
// Reset clears control state and the key words; the table is not cleared.
// ---------------------------------------------------------------------------
`include "blowfish_key1_cipher_macros.svh"

module blowfish_key1_cipher #(
	parameter int TABLE_WORDS = bfk_pkg::TABLE_WORDS
) (
	input  logic        clk,
	input  logic        arst_n,
	bfk_req_if.sink     req,
	bfk_rsp_if.source   rsp,
	bfk_cfg_if.sink     cfg
);

	localparam int IW = bfk_pkg::IDX_W;
	localparam logic [IW-1:0] FILL_LAST = IW'(TABLE_WORDS - 2);

	typedef enum logic [13:0] {
		ST_IDLE = 14'b00000000000001,
		ST_RK   = 14'b00000000000010,
		ST_SA   = 14'b00000000000100,
		ST_SB   = 14'b00000000001000,
		ST_SC   = 14'b00000000010000,
		ST_SD   = 14'b00000000100000,
		ST_SE   = 14'b00000001000000,
		ST_WA   = 14'b00000010000000,
		ST_WB   = 14'b00000100000000,
		ST_XR   = 14'b00001000000000,
		ST_XW   = 14'b00010000000000,
		ST_FW0  = 14'b00100000000000,
		ST_FW1  = 14'b01000000000000,
		ST_DONE = 14'b10000000000000
	} state_t;

	typedef enum logic [1:0] {
		CTX_OP   = 2'd0,
		CTX_E1   = 2'd1,
		CTX_E2   = 2'd2,
		CTX_FILL = 2'd3
	} ctx_t;

	state_t      state_q;
	ctx_t        ctx_q;
	logic        dec_q;
	logic        third_q;
	logic [1:0]  pass_q;
	logic [3:0]  round_q;
	logic [IW-1:0] idx_q;
	logic [31:0] x_q, y_q, z_q, f_q;
	logic [31:0] kw0_q, kw1_q, kw2_q;
	logic [31:0] game_code_q;
	logic        out_valid_q;
	logic [31:0] out_low_q, out_high_q;

	// Key table memory.
	logic [31:0] mem [TABLE_WORDS];
	logic [31:0] rdata_q;
	logic [IW-1:0] raddr, waddr;
	logic [31:0] wdata;
	logic        we;

	logic        in_acc;
	logic [31:0] z_now, f_new, y_fin;
	logic [3:0]  round_nx;

	assign in_acc    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid    = out_valid_q;
	assign rsp.out_low  = out_low_q;
	assign rsp.out_high = out_high_q;

	assign z_now    = rdata_q ^ x_q;
	assign f_new    = f_q + rdata_q;
	assign y_fin    = y_q ^ rdata_q;
	assign round_nx = round_q + 4'd1;

	// Round key address for a given round.
	function automatic logic [IW-1:0] rk_addr(input logic dec, input logic [3:0] r);
		return dec ? (bfk_pkg::KEY_LAST - {{(IW-4){1'b0}}, r}) : {{(IW-4){1'b0}}, r};
	endfunction

	// Read address selection.
	always_comb begin
		case (state_q)
			ST_RK: raddr = rk_addr(dec_q, round_q);
			ST_SA: raddr = bfk_pkg::SBOX0 + {3'd0, z_now[31:24]};
			ST_SB: raddr = bfk_pkg::SBOX1 + {3'd0, z_q[23:16]};
			ST_SC: raddr = bfk_pkg::SBOX2 + {3'd0, z_q[15:8]};
			ST_SD: raddr = bfk_pkg::SBOX3 + {3'd0, z_q[7:0]};
			ST_SE: begin
				if (round_q == 4'd15) begin
					raddr = dec_q ? bfk_pkg::WHITEN_D0 : bfk_pkg::WHITEN_E0;
				end else begin
					raddr = rk_addr(dec_q, round_nx);
				end
			end
			ST_WA: raddr = dec_q ? bfk_pkg::WHITEN_D1 : bfk_pkg::WHITEN_E1;
			ST_XR: raddr = idx_q;
			default: raddr = '0;
		endcase
	end

	// Write port selection.
	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = x_q;
		case (state_q)
			ST_IDLE: begin
				we    = in_acc && (req.func == bfk_pkg::FUNC_LOAD) &&
					(32'(req.table_index) < 32'(TABLE_WORDS));
				waddr = req.table_index;
				wdata = req.table_word;
			end
			ST_XW: begin
				we    = 1'b1;
				wdata = rdata_q ^ bfk_pkg::byte_swap(idx_q[0] ? kw1_q : kw0_q);
			end
			ST_FW0: begin
				we    = 1'b1;
				wdata = y_q;
			end
			ST_FW1: begin
				we    = 1'b1;
				waddr = idx_q + IW'(1);
				wdata = x_q;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			game_code_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			game_code_q <= cfg.data;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ctx_q       <= CTX_OP;
			dec_q       <= 1'b0;
			third_q     <= 1'b0;
			pass_q      <= '0;
			round_q     <= '0;
			idx_q       <= '0;
			kw0_q       <= '0;
			kw1_q       <= '0;
			kw2_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A taken beat frees the output register unless a new result lands.
			if (rsp.valid && rsp.ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						round_q <= '0;
						case (req.func)
							bfk_pkg::FUNC_LOAD: begin
								x_q     <= '0;
								y_q     <= '0;
								state_q <= ST_DONE;
							end
							bfk_pkg::FUNC_KEY: begin
								kw0_q   <= game_code_q;
								kw1_q   <= game_code_q >> 1;
								kw2_q   <= game_code_q << 1;
								x_q     <= game_code_q << 1;
								y_q     <= game_code_q >> 1;
								third_q <= req.third_pass;
								pass_q  <= '0;
								dec_q   <= 1'b0;
								ctx_q   <= CTX_E1;
								state_q <= ST_RK;
							end
							default: begin
								x_q     <= req.block_high;
								y_q     <= req.block_low;
								dec_q   <= (req.func == bfk_pkg::FUNC_DEC);
								ctx_q   <= CTX_OP;
								state_q <= ST_RK;
							end
						endcase
					end
				end
				ST_RK: state_q <= ST_SA;
				ST_SA: begin
					z_q     <= z_now;
					state_q <= ST_SB;
				end
				ST_SB: begin
					f_q     <= rdata_q;
					state_q <= ST_SC;
				end
				ST_SC: begin
					f_q     <= f_q + rdata_q;
					state_q <= ST_SD;
				end
				ST_SD: begin
					f_q     <= f_q ^ rdata_q;
					state_q <= ST_SE;
				end
				ST_SE: begin
					x_q <= y_q ^ f_new;
					y_q <= z_q;
					if (round_q == 4'd15) begin
						state_q <= ST_WA;
					end else begin
						round_q <= round_nx;
						state_q <= ST_SA;
					end
				end
				ST_WA: begin
					x_q     <= x_q ^ rdata_q;
					state_q <= ST_WB;
				end
				ST_WB: begin
					round_q <= '0;
					case (ctx_q)
						CTX_E1: begin
							kw1_q   <= x_q;
							kw2_q   <= y_fin;
							y_q     <= kw0_q;
							ctx_q   <= CTX_E2;
							state_q <= ST_RK;
						end
						CTX_E2: begin
							kw0_q   <= x_q;
							kw1_q   <= y_fin;
							idx_q   <= '0;
							state_q <= ST_XR;
						end
						CTX_FILL: begin
							y_q     <= y_fin;
							state_q <= ST_FW0;
						end
						default: begin
							y_q     <= y_fin;
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_XR: state_q <= ST_XW;
				ST_XW: begin
					if (idx_q == bfk_pkg::KEY_LAST) begin
						idx_q   <= '0;
						x_q     <= '0;
						y_q     <= '0;
						round_q <= '0;
						ctx_q   <= CTX_FILL;
						state_q <= ST_RK;
					end else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= ST_XR;
					end
				end
				ST_FW0: state_q <= ST_FW1;
				ST_FW1: begin
					round_q <= '0;
					if (idx_q != FILL_LAST) begin
						idx_q   <= idx_q + IW'(2);
						x_q     <= y_q;
						y_q     <= x_q;
						state_q <= ST_RK;
					end else if (pass_q == 2'd0) begin
						// Second key pass with the key words as they stand.
						pass_q  <= 2'd1;
						x_q     <= kw2_q;
						y_q     <= kw1_q;
						ctx_q   <= CTX_E1;
						state_q <= ST_RK;
					end else if (pass_q == 2'd1) begin
						// Adjust the key words; run the third pass if asked.
						kw1_q <= kw1_q << 1;
						kw2_q <= kw2_q >> 1;
						if (third_q) begin
							pass_q  <= 2'd2;
							x_q     <= kw2_q >> 1;
							y_q     <= kw1_q << 1;
							ctx_q   <= CTX_E1;
							state_q <= ST_RK;
						end else begin
							x_q     <= '0;
							y_q     <= '0;
							state_q <= ST_DONE;
						end
					end else begin
						x_q     <= '0;
						y_q     <= '0;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// Hand the result to the output register once it is free.
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_low_q   <= x_q;
						out_high_q  <= y_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Checks on the sequencer.
	`BFK_ASSERT_NEXT(a_enc_starts, in_acc && (req.func == bfk_pkg::FUNC_ENC), state_q == ST_RK)
	`BFK_ASSERT_NOW(a_fill_even, state_q == ST_FW1, idx_q[0] == 1'b0)
	`BFK_ASSERT_NOW(a_xor_range, state_q == ST_XW, idx_q <= bfk_pkg::KEY_LAST)

endmodule

// ----- verif/blowfish_key1_cipher_tb.sv -----
// ---------------------------------------------------------------------------
// blowfish_key1_cipher_tb
// Self-checking regression for the KEY1 Blowfish cipher. It fills the key
// table, encrypts and decrypts, runs the key schedule with several game codes,
// then mixes blocks and table reloads. Requests idle and responses stall at random.
// Each response beat is checked against a predictor kept in the bench.
// ---------------------------------------------------------------------------
module blowfish_key1_cipher_tb;

	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [31:0] lo;
		logic [31:0] hi;
	} block_t;

	logic clk;
	logic arst_n;

	bfk_req_if req_if ();
	bfk_rsp_if rsp_if ();
	bfk_cfg_if cfg_if ();

	blowfish_key1_cipher i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	// Predicted state of the block.
	logic [31:0] key_tbl [bfk_pkg::TABLE_WORDS];
	logic [31:0] seed_words [3];
	logic [31:0] code_reg;

	block_t      blocks_due [$];
	int          fail_count;
	int          beat_count;
	int          enc_count;
	int          dec_count;
	int          load_count;
	int          sched_count;
	int          cycle_count;
	int          send_idle_pct;
	int          rsp_stall_pct;
	block_t      last_cipher;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Round mixing function over the four S-boxes.
	function automatic logic [31:0] sbox_mix(input logic [31:0] z);
		logic [31:0] f;
		f = key_tbl[bfk_pkg::SBOX0 + z[31:24]];
		f = key_tbl[bfk_pkg::SBOX1 + z[23:16]] + f;
		f = key_tbl[bfk_pkg::SBOX2 + z[15:8]] ^ f;
		f = key_tbl[bfk_pkg::SBOX3 + z[7:0]] + f;
		return f;
	endfunction

	function automatic block_t encipher(input block_t b);
		logic [31:0] x, y, z;
		block_t      r;
		x = b.hi;
		y = b.lo;
		for (int k = 0; k < 16; k++) begin
			z = key_tbl[k] ^ x;
			x = y ^ sbox_mix(z);
			y = z;
		end
		r.lo = x ^ key_tbl[16];
		r.hi = y ^ key_tbl[17];
		return r;
	endfunction

	function automatic block_t decipher(input block_t b);
		logic [31:0] x, y, z;
		block_t      r;
		x = b.hi;
		y = b.lo;
		for (int k = 17; k > 1; k--) begin
			z = key_tbl[k] ^ x;
			x = y ^ sbox_mix(z);
			y = z;
		end
		r.lo = x ^ key_tbl[1];
		r.hi = y ^ key_tbl[0];
		return r;
	endfunction

	// One key pass: scramble the seed words, fold them into the round keys,
	// then regenerate the whole table from a running zero block.
	function automatic void key_pass();
		block_t b;
		logic [31:0] sw;
		b = encipher('{lo: seed_words[1], hi: seed_words[2]});
		seed_words[1] = b.lo;
		seed_words[2] = b.hi;
		b = encipher('{lo: seed_words[0], hi: seed_words[1]});
		seed_words[0] = b.lo;
		seed_words[1] = b.hi;
		for (int k = 0; k < 18; k++) begin
			sw = seed_words[k % 2];
			key_tbl[k] ^= {sw[7:0], sw[15:8], sw[23:16], sw[31:24]};
		end
		b = '0;
		for (int k = 0; k < bfk_pkg::TABLE_WORDS; k += 2) begin
			b = encipher(b);
			key_tbl[k] = b.hi;
			if (k + 1 < bfk_pkg::TABLE_WORDS)
				key_tbl[k + 1] = b.lo;
		end
	endfunction

	function automatic void key_schedule(input logic third);
		seed_words[0] = code_reg;
		seed_words[1] = code_reg >> 1;
		seed_words[2] = code_reg << 1;
		key_pass();
		key_pass();
		seed_words[1] = seed_words[1] << 1;
		seed_words[2] = seed_words[2] >> 1;
		if (third)
			key_pass();
	endfunction

	// Predict the response to one accepted request beat.
	function automatic block_t predict_block(input logic [1:0] fn, input logic [10:0] idx,
		input logic [31:0] word, input logic third, input block_t b);
		block_t r;
		r = '0;
		case (fn)
			bfk_pkg::FUNC_LOAD: begin
				if (idx < bfk_pkg::TABLE_WORDS)
					key_tbl[idx] = word;
				load_count++;
			end
			bfk_pkg::FUNC_KEY: begin
				key_schedule(third);
				sched_count++;
			end
			bfk_pkg::FUNC_ENC: begin
				r = encipher(b);
				enc_count++;
			end
			default: begin
				r = decipher(b);
				dec_count++;
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch at beat %0d: %s got %08h expected %08h",
			beat_count, what, got, want);
		fail_count++;
	endtask

	// Send one request beat, with random idle cycles ahead of it.
	task automatic send_req(input logic [1:0] fn, input logic [10:0] idx,
		input logic [31:0] word, input logic third, input block_t b);
		block_t r;
		if ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			req_if.valid <= 1'b0;
			while ($urandom_range(99) < send_idle_pct)
				@(negedge clk);
		end
		@(negedge clk);
		req_if.valid       <= 1'b1;
		req_if.func        <= fn;
		req_if.table_index <= idx;
		req_if.table_word  <= word;
		req_if.third_pass  <= third;
		req_if.block_low   <= b.lo;
		req_if.block_high  <= b.hi;
		forever begin
			@(posedge clk);
			if (req_if.ready)
				break;
		end
		r = predict_block(fn, idx, word, third, b);
		if (fn == bfk_pkg::FUNC_ENC)
			last_cipher = r;
		blocks_due.push_back(r);
	endtask

	// Lower valid and wait until every response has come back.
	task automatic drain();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (blocks_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_code(input logic [31:0] code);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= code;
		forever begin
			@(posedge clk);
			if (cfg_if.ready)
				break;
		end
		code_reg = code;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	function automatic block_t rand_block();
		return '{lo: $urandom, hi: $urandom};
	endfunction

	// Fill the whole table so that no later read hits an unwritten word.
	task automatic test_table_fill();
		for (int k = 0; k < bfk_pkg::TABLE_WORDS; k++) begin
			logic [31:0] w;
			w = (k == 0) ? 32'h0 : (k == 1) ? 32'hffff_ffff : $urandom;
			send_req(bfk_pkg::FUNC_LOAD, k[10:0], w, 1'b0, rand_block());
		end
		// Out-of-range loads are dropped but still answered.
		send_req(bfk_pkg::FUNC_LOAD, 11'd1042, 32'hdead_beef, 1'b1, rand_block());
		send_req(bfk_pkg::FUNC_LOAD, 11'h7ff, 32'hffff_ffff, 1'b0, rand_block());
		drain();
	endtask

	// Block extremes in both directions.
	task automatic test_block_extremes();
		block_t pats [4];
		pats[0] = '0;
		pats[1] = '1;
		pats[2] = {32'haaaa_aaaa, 32'h5555_5555};
		pats[3] = {32'h5555_5555, 32'haaaa_aaaa};
		foreach (pats[k]) begin
			send_req(bfk_pkg::FUNC_ENC, 11'h0, 32'h0, 1'b0, pats[k]);
			send_req(bfk_pkg::FUNC_DEC, 11'h7ff, 32'hffff_ffff, 1'b1, pats[k]);
		end
		send_req(bfk_pkg::FUNC_DEC, 11'h0, 32'h0, 1'b0, last_cipher);
		drain();
	endtask

	// Key schedule with a given code, followed by a round trip check.
	task automatic test_key_schedule(input logic [31:0] code, input logic third);
		write_code(code);
		send_req(bfk_pkg::FUNC_KEY, 11'($urandom_range(2047)), $urandom, third,
			rand_block());
		send_req(bfk_pkg::FUNC_ENC, 11'h0, 32'h0, 1'b0, rand_block());
		send_req(bfk_pkg::FUNC_DEC, 11'h0, 32'h0, 1'b0, last_cipher);
		drain();
	endtask

	// Random traffic: mostly blocks, some table reloads and round trips.
	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
		input int n_items);
		int sel;
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		write_code($urandom);
		for (int k = 0; k < n_items; k++) begin
			sel = $urandom_range(99);
			if (sel < 40)
				send_req(bfk_pkg::FUNC_ENC, 11'($urandom_range(2047)), $urandom,
					1'($urandom_range(1)), rand_block());
			else if (sel < 60)
				send_req(bfk_pkg::FUNC_DEC, 11'($urandom_range(2047)), $urandom,
					1'($urandom_range(1)), rand_block());
			else if (sel < 75)
				send_req(bfk_pkg::FUNC_DEC, 11'($urandom_range(2047)), $urandom,
					1'($urandom_range(1)), last_cipher);
			else if (sel < 95)
				send_req(bfk_pkg::FUNC_LOAD,
					11'($urandom_range(bfk_pkg::TABLE_WORDS - 1)), $urandom,
					1'($urandom_range(1)), rand_block());
			else
				send_req(bfk_pkg::FUNC_LOAD,
					11'($urandom_range(2047, bfk_pkg::TABLE_WORDS)), $urandom,
					1'($urandom_range(1)), rand_block());
		end
		drain();
	endtask

	// Receiver stalls.
	always @(negedge clk)
		rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);

	// Check each response beat against the oldest prediction.
	always @(posedge clk) begin
		block_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (blocks_due.size() == 0) begin
				report_mismatch("unexpected out_low", rsp_if.out_low, 32'h0);
			end else begin
				want = blocks_due.pop_front();
				if (rsp_if.out_low !== want.lo)
					report_mismatch("out_low", rsp_if.out_low, want.lo);
				if (rsp_if.out_high !== want.hi)
					report_mismatch("out_high", rsp_if.out_high, want.hi);
			end
			beat_count++;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("blowfish_key1_cipher regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n             = 1'b0;
		req_if.valid       = 1'b0;
		req_if.func        = bfk_pkg::FUNC_LOAD;
		req_if.table_index = '0;
		req_if.table_word  = '0;
		req_if.third_pass  = 1'b0;
		req_if.block_low   = '0;
		req_if.block_high  = '0;
		cfg_if.valid       = 1'b0;
		cfg_if.data        = '0;
		seed_words         = '{default: '0};
		code_reg           = '0;
		last_cipher        = '0;
		fail_count         = 0;
		beat_count         = 0;
		enc_count          = 0;
		dec_count          = 0;
		load_count         = 0;
		sched_count        = 0;
		cycle_count        = 0;
		send_idle_pct      = 0;
		rsp_stall_pct      = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_table_fill();
		test_block_extremes();
		test_key_schedule(32'h0, 1'b0);
		test_key_schedule(32'hffff_ffff, 1'b1);
		test_key_schedule($urandom, 1'b0);
		test_random_traffic(0, 0, 170);
		test_random_traffic(73, 0, 160);
		test_random_traffic(0, 73, 160);
		test_random_traffic(73, 73, 160);
		test_random_traffic(10, 10, 60);

		repeat (200) @(posedge clk);
		$display("covered %0d loads, %0d key schedules, %0d encrypts, %0d decrypts",
			load_count, sched_count, enc_count, dec_count);
		$display("%0d response beats checked in %0d cycles", beat_count, cycle_count);
		if (fail_count == 0 && blocks_due.size() == 0) begin
			$display("blowfish_key1_cipher regression: pass");
		end else begin
			$display("%0d mismatches, %0d responses missing", fail_count,
				blocks_due.size());
			$display("blowfish_key1_cipher regression: fail");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/bfk_pkg.sv
hw/rtl/bfk_ifs.sv
hw/rtl/blowfish_key1_cipher.sv
verif/blowfish_key1_cipher_tb.sv
